// ===== rtl/dmsel_pkg.sv =====
`default_nettype none

package dmsel_pkg;

  localparam int COUNTER_BITS  = 16;
  localparam int CNT_OUT_W     = 16;
  localparam int MODE_W        = 3;
  localparam int SW_W          = 2;
  localparam int CAUSE_W       = 3;
  localparam int FILT_W        = 8;
  localparam int IN_DATA_W     = 8;
  localparam int OUT_DATA_W    = 64;

  localparam logic [FILT_W-1:0] FILTER_COUNT_RESET = FILT_W'(10);

  typedef logic [MODE_W-1:0]  mode_t;
  typedef logic [CAUSE_W-1:0] cause_t;

  localparam mode_t MODE_STOP           = MODE_W'(0);
  localparam mode_t MODE_FOLLOW         = MODE_W'(1);
  localparam mode_t MODE_SPIN           = MODE_W'(2);
  localparam mode_t MODE_SPIN_TRANSLATE = MODE_W'(3);
  localparam mode_t MODE_MANUAL         = MODE_W'(4);

  localparam logic [SW_W-1:0] SW_UP     = SW_W'(0);
  localparam logic [SW_W-1:0] SW_MIDDLE = SW_W'(1);
  localparam logic [SW_W-1:0] SW_DOWN   = SW_W'(2);

  localparam logic OP_TICK    = 1'b0;
  localparam logic OP_REQUEST = 1'b1;

  localparam cause_t CAUSE_NONE    = CAUSE_W'(0);
  localparam cause_t CAUSE_OFFLINE = CAUSE_W'(1);
  localparam cause_t CAUSE_SWITCH  = CAUSE_W'(2);

  typedef struct packed {
    logic             opcode;
    logic             offline;
    logic [SW_W-1:0]  switch_left;
    logic [SW_W-1:0]  switch_right;
    cause_t           request_cause;
  } item_t;

  typedef struct packed {
    mode_t                   active;
    mode_t                   confirmed;
    mode_t                   candidate;
    logic [FILT_W-1:0]       repeat_cnt;
    logic [COUNTER_BITS-1:0] changes;
    logic [COUNTER_BITS-1:0] rejects;
    cause_t                  cause;
    logic                    online;
  } sel_state_t;

endpackage

`default_nettype wire

// ===== rtl/dmsel_next.sv =====
`default_nettype none

module dmsel_next (
  input  var dmsel_pkg::sel_state_t            st,
  input  var dmsel_pkg::item_t                 item,
  input  var logic [dmsel_pkg::FILT_W-1:0]     filter_count,
  output var dmsel_pkg::sel_state_t            st_next,
  output var logic [dmsel_pkg::OUT_DATA_W-1:0] result
);
  import dmsel_pkg::*;

  mode_t             raw;
  logic [FILT_W:0]   rep_inc;
  logic              is_stopped;

  function automatic mode_t decode_raw(input logic [SW_W-1:0] left,
                                       input logic [SW_W-1:0] right);
    mode_t m;
    m = MODE_MANUAL;
    if (left == SW_DOWN && right == SW_DOWN) begin
      m = MODE_STOP;
    end else if (left == SW_MIDDLE) begin
      m = (right == SW_UP) ? MODE_SPIN : MODE_FOLLOW;
    end else if (left == SW_UP) begin
      m = (right == SW_MIDDLE) ? MODE_SPIN_TRANSLATE : MODE_MANUAL;
    end
    return m;
  endfunction

  assign raw        = decode_raw(item.switch_left, item.switch_right);
  assign rep_inc    = {1'b0, st.repeat_cnt} + (FILT_W+1)'(1);
  assign is_stopped = (st.active == MODE_STOP);

  always_comb begin
    st_next = st;
    priority if (item.opcode == OP_REQUEST) begin
      if (!is_stopped) begin
        st_next.active  = MODE_STOP;
        st_next.cause   = item.request_cause;
        st_next.changes = st.changes + COUNTER_BITS'(1);
      end
    end else if (item.offline) begin
      // Offline forces stop but leaves the debounce filter alone.
      st_next.online = 1'b0;
      if (!is_stopped) begin
        st_next.active  = MODE_STOP;
        st_next.cause   = CAUSE_OFFLINE;
        st_next.changes = st.changes + COUNTER_BITS'(1);
      end
    end else if (raw == MODE_STOP) begin
      st_next.online = 1'b1;
      if (!is_stopped) begin
        st_next.active     = MODE_STOP;
        st_next.confirmed  = MODE_STOP;
        st_next.candidate  = MODE_STOP;
        st_next.cause      = CAUSE_SWITCH;
        st_next.repeat_cnt = '0;
        st_next.changes    = st.changes + COUNTER_BITS'(1);
      end
    end else if (raw == st.candidate) begin
      st_next.online     = 1'b1;
      st_next.repeat_cnt = rep_inc[FILT_W-1:0];
      if (rep_inc >= {1'b0, filter_count}) begin
        st_next.repeat_cnt = filter_count;
        // A latched stop is released only by a newly confirmed mode.
        if (st.candidate != st.confirmed) begin
          st_next.confirmed = st.candidate;
          st_next.active    = st.candidate;
          st_next.changes   = st.changes + COUNTER_BITS'(1);
        end
      end
    end else begin
      st_next.online     = 1'b1;
      st_next.candidate  = raw;
      st_next.repeat_cnt = FILT_W'(1);
      st_next.rejects    = st.rejects + COUNTER_BITS'(1);
    end
  end

  always_comb begin
    result        = '0;
    result[0]     = (st_next.active == MODE_STOP);
    result[1]     = (st_next.active == MODE_FOLLOW);
    result[2]     = (st_next.active == MODE_SPIN) ||
                    (st_next.active == MODE_SPIN_TRANSLATE);
    result[3]     = (st_next.active == MODE_MANUAL) ||
                    (st_next.active == MODE_SPIN_TRANSLATE);
    result[6:4]   = st_next.active;
    result[9:7]   = st_next.confirmed;
    result[12:10] = st_next.candidate;
    result[20:13] = st_next.repeat_cnt;
    result[36:21] = CNT_OUT_W'(st_next.changes);
    result[52:37] = CNT_OUT_W'(st_next.rejects);
    result[55:53] = st_next.cause;
    result[56]    = st_next.online;
  end

endmodule

`default_nettype wire

// ===== rtl/debounced_drive_mode_selector_core.sv =====
`default_nettype none

// Channel   Direction  Fields (lowest bit first)
// s_*       in         tuser: opcode; tdata: remote_offline, switch_left,
//                      switch_right, request_cause
// m_*       out        tdata: one result word per accepted word
// cfg_*     in         cfg_data: filter_count
//
// An accepted word is held in an input register and its result is written to the
// output register on the next edge at which that register is free; while the
// output is not stalled, one word can be taken every cycle.
// The mode state updates at the same edge as the output register, so back-to-back
// words see each other's effects. A stalled output holds the input register,
// which then lowers s_tready. Reset clears the mode state, counters and both
// valid flags, and loads filter_count with 10. cfg_ready is always high.

module debounced_drive_mode_selector_core (
  input  var logic                            clk,
  input  var logic                            rst,
  input  var logic                            s_tvalid,
  output var logic                            s_tready,
  input  var logic [dmsel_pkg::IN_DATA_W-1:0] s_tdata,   // offline, left, right, cause
  input  var logic                            s_tuser,   // opcode
  output var logic                            m_tvalid,
  input  var logic                            m_tready,
  // flag_stop, flag_follow, flag_rotating, flag_universal, active_mode,
  // confirmed_mode, candidate_mode, repeat_count, changes_total, rejects_total,
  // stop_cause, online flag, zero fill
  output var logic [dmsel_pkg::OUT_DATA_W-1:0] m_tdata,
  input  var logic                            cfg_valid,
  output var logic                            cfg_ready,
  input  var logic [dmsel_pkg::FILT_W-1:0]    cfg_data
);
  import dmsel_pkg::*;

  logic                  pend_valid;
  item_t                 pend_item;
  sel_state_t            st;
  sel_state_t            st_next;
  logic [FILT_W-1:0]     filter_count;
  logic [OUT_DATA_W-1:0] result;
  logic                  advance;

  assign advance   = pend_valid && (!m_tvalid || m_tready);
  assign s_tready  = !pend_valid || advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_count <= FILTER_COUNT_RESET;
    end else if (cfg_valid) begin
      filter_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (s_tready) begin
      pend_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      pend_item.opcode        <= s_tuser;
      pend_item.offline       <= s_tdata[0];
      pend_item.switch_left   <= s_tdata[2:1];
      pend_item.switch_right  <= s_tdata[4:3];
      pend_item.request_cause <= s_tdata[7:5];
    end
  end

  dmsel_next u_next (
    .st           (st),
    .item         (pend_item),
    .filter_count (filter_count),
    .st_next      (st_next),
    .result       (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st.active     <= MODE_STOP;
      st.confirmed  <= MODE_STOP;
      st.candidate  <= MODE_STOP;
      st.repeat_cnt <= '0;
      st.changes    <= '0;
      st.rejects    <= '0;
      st.cause      <= CAUSE_NONE;
      st.online     <= 1'b0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= result;
    end
  end

  // The active mode is either stop or the confirmed mode.
  a_active_mode: assert property (@(posedge clk) disable iff (rst)
    (st.active == MODE_STOP) || (st.active == st.confirmed))
    else $error("active mode differs from confirmed mode while not stopped");

  // A nonzero repeat count always belongs to a normal candidate.
  a_candidate: assert property (@(posedge clk) disable iff (rst)
    (st.repeat_cnt != '0) |-> (st.candidate != MODE_STOP))
    else $error("repeat count running on a stop candidate");

  // The mode state changes only when a word moves to the output register.
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    ($past(!rst) && !$past(advance)) |-> (st == $past(st)))
    else $error("mode state changed without a word being processed");

endmodule

`default_nettype wire
